FILE: rtl/core/bitmap_slot_allocator_unit_macros.svh
// Assertion macros for the bitmap slot allocator.
// Included by bitmap_slot_allocator_unit.sv; expects i_clk and i_rst_n in scope.
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bsa_pkg.sv
// Shared types, codes and helper functions of the bitmap slot allocator.
// No dependencies; imported by bsa_map_ram and bitmap_slot_allocator_unit.
package bsa_pkg;

    localparam int WORD_BITS = 32;
    localparam int NUM_W     = 14;
    localparam logic [NUM_W-1:0] LIMIT_RESET = 14'd8192;
    localparam logic [NUM_W-1:0] COUNT_MAX   = 14'h3FFF;

    typedef enum logic [1:0] {ST_OK, ST_FULL, ST_RANGE, ST_CLEAR} t_status;
    typedef enum logic {ACT_ALLOC, ACT_FREE} t_action;
    typedef enum logic {POOL_INODE, POOL_BLOCK} t_pool;
    typedef enum logic {CFG_INODE_LIMIT, CFG_BLOCK_LIMIT} t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SRD, S_SCHK, S_RD, S_CHK, S_DONE
    } t_state;

    typedef struct packed {
        logic             action;
        logic             pool;
        logic [NUM_W-1:0] slot_number;
    } t_in_beat;

    typedef struct packed {
        logic [NUM_W-1:0] granted_number;
        t_status          status;
        logic [NUM_W-1:0] free_left;
    } t_out_beat;

    typedef struct packed {
        logic data_we;
        logic sum_we;
    } t_ram_ctl;

    // Position of the lowest zero bit, found by halving the word five times.
    function automatic logic [4:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [4:0]           pos;
        v   = ~w;
        pos = '0;
        for (int s = 4; s >= 0; s--) begin
            if ((v & ((32'd1 << (32'd1 << s)) - 32'd1)) == '0) begin
                pos[s] = 1'b1;
                v      = v >> (32'd1 << s);
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/core/bsa_map_ram.sv
// Bitmap word memory and row-full summary memory for both pools.
// Depends on bsa_pkg; instantiated by bitmap_slot_allocator_unit.
module bsa_map_ram
    import bsa_pkg::*;
#(
    parameter int SUM_W = 3
) (
    input  logic                 i_clk,
    input  t_ram_ctl             i_ctl,
    input  logic [SUM_W+5:0]     i_data_addr,
    input  logic [WORD_BITS-1:0] i_data_wdata,
    input  logic [SUM_W:0]       i_sum_addr,
    input  logic [WORD_BITS-1:0] i_sum_wdata,
    output logic [WORD_BITS-1:0] o_data_rdata,
    output logic [WORD_BITS-1:0] o_sum_rdata
);

    localparam int DATA_DEPTH = 2 ** (SUM_W + 6);
    localparam int SUM_DEPTH  = 2 ** (SUM_W + 1);

    logic [WORD_BITS-1:0] r_data_mem [DATA_DEPTH];
    logic [WORD_BITS-1:0] r_sum_mem  [SUM_DEPTH];
    logic [WORD_BITS-1:0] r_data_rd;
    logic [WORD_BITS-1:0] r_sum_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.data_we) begin
            r_data_mem[i_data_addr] <= i_data_wdata;
        end
        r_data_rd <= r_data_mem[i_data_addr];
    end

    // Bit r of a summary word is set when row r of that group is completely used.
    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_we) begin
            r_sum_mem[i_sum_addr] <= i_sum_wdata;
        end
        r_sum_rd <= r_sum_mem[i_sum_addr];
    end

    assign o_data_rdata = r_data_rd;
    assign o_sum_rdata  = r_sum_rd;

endmodule

FILE: rtl/core/bitmap_slot_allocator_unit.sv
// Top level of the bitmap slot allocator: sequencer, counters and config registers.
// Depends on bsa_pkg, bsa_map_ram and bitmap_slot_allocator_unit_macros.svh.
//
//   Channel  Handshake                     Payload
//   -------  ----------------------------  --------------------------------
//   in       i_in_valid / o_in_stall       i_in  (action, pool, slot_number)
//   out      o_out_valid / i_out_stall     o_out (granted_number, status, free_left)
//   cfg      i_cfg_we                      i_cfg_idx, i_cfg_data
//
// A free goes through read, check and done before the next beat can be taken; a free out
// of range goes straight to done. An allocate reads and checks one summary word (32 rows)
// per scan step, at most k = 2**SUM_W words, then reads, checks and updates one map word;
// a scan that finds every row used skips that word. After reset both maps are cleared one
// word a cycle, all 2**(SUM_W+6) words (512 at MAP_BITS = 8192), before any input beat.
// A held result does not block the next accept; only delivery of a further result waits.
`include "bitmap_slot_allocator_unit_macros.svh"

module bitmap_slot_allocator_unit
    import bsa_pkg::*;
#(
    parameter int MAP_BITS = 8192
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [NUM_W-1:0] i_cfg_data
);

    localparam int GROUPS = (MAP_BITS + 1023) / 1024;
    localparam int SUM_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int IDX_W  = SUM_W + 10;
    localparam int CW     = (IDX_W + 1 > NUM_W) ? IDX_W + 1 : NUM_W;

    t_state               r_state, n_state;
    logic [SUM_W+5:0]     r_clr, n_clr;
    logic                 r_action, n_action;
    logic                 r_pool, n_pool;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CW-1:0]        r_lim, n_lim;
    logic [SUM_W-1:0]     r_sidx, n_sidx;
    logic [NUM_W-1:0]     r_gnt, n_gnt;
    t_status              r_status, n_status;
    logic [NUM_W-1:0]     r_inode_lim, n_inode_lim;
    logic [NUM_W-1:0]     r_block_lim, n_block_lim;
    logic [NUM_W-1:0]     r_inode_used, n_inode_used;
    logic [NUM_W-1:0]     r_block_used, n_block_used;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    t_ram_ctl             ram_ctl;
    logic [SUM_W+5:0]     data_addr;
    logic [SUM_W:0]       sum_addr;
    logic [WORD_BITS-1:0] data_wdata, sum_wdata, data_rd, sum_rd;

    logic                 in_acc;
    logic [NUM_W-1:0]     in_lim_raw;
    logic [CW-1:0]        in_lim, in_num;
    logic                 free_ok;
    logic [IDX_W-1:0]     free_idx;
    logic [4:0]           zpos;
    logic [IDX_W-1:0]     alloc_idx;
    logic                 alloc_ok;
    logic [WORD_BITS-1:0] bit_mask, new_word;
    logic                 chk_write;
    logic [NUM_W-1:0]     cur_used, used_inc, used_dec, free_left;
    logic                 out_free;

    bsa_map_ram #(
        .SUM_W (SUM_W)
    ) u_map_ram (
        .i_clk        (i_clk),
        .i_ctl        (ram_ctl),
        .i_data_addr  (data_addr),
        .i_data_wdata (data_wdata),
        .i_sum_addr   (sum_addr),
        .i_sum_wdata  (sum_wdata),
        .o_data_rdata (data_rd),
        .o_sum_rdata  (sum_rd)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Effective limit of the requested pool and the range check of a free.
    assign in_lim_raw = (i_in.pool == POOL_BLOCK) ? r_block_lim : r_inode_lim;
    assign in_lim     = (CW'(in_lim_raw) < CW'(MAP_BITS)) ? CW'(in_lim_raw) : CW'(MAP_BITS);
    assign in_num     = CW'(i_in.slot_number);
    assign free_ok    = (i_in.pool == POOL_BLOCK) ? (in_num < in_lim)
                                                  : ((in_num != '0) && (in_num <= in_lim));
    assign free_idx   = (i_in.pool == POOL_BLOCK) ? IDX_W'(in_num) : IDX_W'(in_num - CW'(1));

    // One zero finder serves the summary scan and the word check in turn.
    assign zpos      = lowest_zero((r_state == S_SCHK) ? sum_rd : data_rd);

    // The lowest clear bit overall is the first fit; past the limit means the pool is full.
    assign alloc_idx = {r_idx[IDX_W-1:5], zpos};
    assign alloc_ok  = CW'(alloc_idx) < r_lim;
    assign bit_mask  = 32'd1 << ((r_action == ACT_FREE) ? r_idx[4:0] : zpos);
    assign new_word  = (r_action == ACT_FREE) ? (data_rd & ~bit_mask) : (data_rd | bit_mask);
    assign chk_write = (r_action == ACT_FREE) ? data_rd[r_idx[4:0]] : alloc_ok;

    assign cur_used  = (r_pool == POOL_BLOCK) ? r_block_used : r_inode_used;
    assign used_inc  = (cur_used != COUNT_MAX) ? cur_used + NUM_W'(1) : cur_used;
    assign used_dec  = (cur_used != '0) ? cur_used - NUM_W'(1) : cur_used;
    assign free_left = (r_lim > CW'(cur_used)) ? NUM_W'(r_lim - CW'(cur_used)) : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == ACT_FREE) begin
                        n_state = free_ok ? S_RD : S_DONE;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD:  n_state = S_SCHK;
            S_SCHK: begin
                if (sum_rd != '1) begin
                    n_state = S_RD;
                end else if (&r_sidx) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_RD:   n_state = S_CHK;
            S_CHK:  n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_clr        = r_clr;
        n_action     = r_action;
        n_pool       = r_pool;
        n_idx        = r_idx;
        n_lim        = r_lim;
        n_sidx       = r_sidx;
        n_gnt        = r_gnt;
        n_status     = r_status;
        n_inode_lim  = r_inode_lim;
        n_block_lim  = r_block_lim;
        n_inode_used = r_inode_used;
        n_block_used = r_block_used;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        ram_ctl      = '0;
        data_addr    = {r_pool, r_idx[IDX_W-1:5]};
        sum_addr     = {r_pool, r_idx[IDX_W-1:10]};
        data_wdata   = new_word;
        sum_wdata    = (sum_rd & ~(32'd1 << r_idx[9:5]))
                     | (WORD_BITS'(&new_word) << r_idx[9:5]);

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INODE_LIMIT: n_inode_lim = i_cfg_data;
                CFG_BLOCK_LIMIT: n_block_lim = i_cfg_data;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_ctl    = '{data_we: 1'b1, sum_we: 1'b1};
                data_addr  = r_clr;
                sum_addr   = r_clr[SUM_W:0];
                data_wdata = '0;
                sum_wdata  = '0;
                n_clr      = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_action = i_in.action;
                    n_pool   = i_in.pool;
                    n_lim    = in_lim;
                    n_sidx   = '0;
                    n_gnt    = '0;
                    if (i_in.action == ACT_FREE) begin
                        n_idx    = free_idx;
                        n_status = free_ok ? ST_OK : ST_RANGE;
                    end else begin
                        n_idx    = '0;
                        n_status = ST_FULL;
                    end
                end
            end
            S_SRD: begin
                sum_addr = {r_pool, r_sidx};
            end
            S_SCHK: begin
                sum_addr = {r_pool, r_sidx};
                if (sum_rd != '1) begin
                    n_idx = {r_sidx, zpos, 5'd0};
                end else begin
                    n_sidx = r_sidx + 1'b1;
                end
            end
            S_RD: begin
            end
            S_CHK: begin
                if (chk_write) begin
                    ram_ctl  = '{data_we: 1'b1, sum_we: 1'b1};
                    n_status = ST_OK;
                    if (r_action == ACT_FREE) begin
                        if (r_pool == POOL_BLOCK) n_block_used = used_dec;
                        else                      n_inode_used = used_dec;
                    end else begin
                        n_gnt = (r_pool == POOL_BLOCK) ? NUM_W'(alloc_idx)
                                                       : NUM_W'(alloc_idx) + NUM_W'(1);
                        if (r_pool == POOL_BLOCK) n_block_used = used_inc;
                        else                      n_inode_used = used_inc;
                    end
                end else begin
                    n_status = (r_action == ACT_FREE) ? ST_CLEAR : ST_FULL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{granted_number: r_gnt, status: r_status,
                                    free_left: free_left};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_inode_lim  <= LIMIT_RESET;
            r_block_lim  <= LIMIT_RESET;
            r_inode_used <= '0;
            r_block_used <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_inode_lim  <= n_inode_lim;
            r_block_lim  <= n_block_lim;
            r_inode_used <= n_inode_used;
            r_block_used <= n_block_used;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_pool   <= n_pool;
        r_idx    <= n_idx;
        r_lim    <= n_lim;
        r_sidx   <= n_sidx;
        r_gnt    <= n_gnt;
        r_status <= n_status;
        r_out    <= n_out;
    end

    `BSA_ASSERT_NOW(a_clear_no_result, r_state == S_CLEAR, !r_out_valid, "result during clear pass")
    `BSA_ASSERT_NOW(a_write_states, ram_ctl.data_we, (r_state == S_CLEAR) || (r_state == S_CHK), "map write outside update step")
    `BSA_ASSERT_NEXT(a_used_stable, r_state != S_CHK, $stable(r_inode_used) && $stable(r_block_used), "used count moved outside update step")
    `BSA_ASSERT_NOW(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "result raised outside done step")

endmodule
